// ===== hdl/mctw_pkg.sv =====
// ----------------------------------------------------------------------------
// mctw_pkg
// shared types, constants and helpers of the multi-channel timeout watchdog
// ----------------------------------------------------------------------------
package mctw_pkg;

	localparam int CHANNELS   = 8;
	localparam int COUNT_BITS = 16;

	localparam int FUNC_W  = 3;
	localparam int CHAN_W  = 3;
	localparam int TMO_W   = 16;
	localparam int MASK_W  = 8;

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	typedef enum logic [FUNC_W-1:0] {
		FN_REGISTER   = 3'd0,
		FN_UNREGISTER = 3'd1,
		FN_ARM        = 3'd2,
		FN_DISARM     = 3'd3,
		FN_TICK       = 3'd4
	} func_t;

	typedef enum logic {
		ST_APPLIED = 1'b0,
		ST_IGNORED = 1'b1
	} status_t;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [MASK_W-1:0]     mask_t;

	// one operation on its way down the row, collecting its result
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CHAN_W-1:0] channel;
		logic [TMO_W-1:0]  timeout_ms;
		mask_t             fired_mask;
		mask_t             flag_mask;
		mask_t             armed_mask;
		logic              status;
	} token_t;

	// clamp a requested timeout to what the counter holds
	function automatic count_t sat_count(input logic [TMO_W-1:0] tmo);
		logic [63:0] t64;
		t64 = 64'(tmo);
		if (t64 > COUNT_MAX) begin
			return COUNT_BITS'(COUNT_MAX);
		end
		return COUNT_BITS'(t64);
	endfunction

endpackage

// ===== hdl/mctw_ifs.sv =====
// ----------------------------------------------------------------------------
// mctw request and response channels
// valid/ready streams carrying the watchdog operations and their results
// ----------------------------------------------------------------------------
interface mctw_req_if;
	import mctw_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CHAN_W-1:0] channel;
	logic [TMO_W-1:0]  timeout_ms;

	modport source (output valid, func, channel, timeout_ms, input ready);
	modport sink   (input valid, func, channel, timeout_ms, output ready);
endinterface

interface mctw_rsp_if;
	import mctw_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] fired_mask;
	logic [MASK_W-1:0] flag_mask;
	logic [MASK_W-1:0] armed_mask;
	logic              status;

	modport source (output valid, fired_mask, flag_mask, armed_mask, status, input ready);
	modport sink   (input valid, fired_mask, flag_mask, armed_mask, status, output ready);
endinterface

// ===== hdl/mctw_cell.sv =====
// ----------------------------------------------------------------------------
// mctw_cell
// one watchdog channel: holds its state, applies a passing operation to it
// and adds its own bits to the operation's result
// ----------------------------------------------------------------------------
module mctw_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            addressable,
	input  logic [2:0]      ch_code,
	input  mctw_pkg::mask_t mask_sel,
	input  mctw_pkg::token_t tok_in,
	output mctw_pkg::token_t tok_out
);
	import mctw_pkg::*;

	logic   present_q, armed_q, flag_q;
	count_t remaining_q;

	logic   present_n, armed_n, flag_n, fire;
	count_t remaining_n, rem_dec;
	logic   hit;
	token_t tok_n;

	assign hit     = addressable && (tok_in.channel == ch_code);
	assign rem_dec = (remaining_q != '0) ? remaining_q - count_t'(1) : '0;

	always_comb begin
		present_n   = present_q;
		armed_n     = armed_q;
		flag_n      = flag_q;
		remaining_n = remaining_q;
		fire        = 1'b0;
		tok_n       = tok_in;
		case (tok_in.func)
			FN_REGISTER: begin
				if (hit) begin
					present_n    = 1'b1;
					armed_n      = 1'b0;
					flag_n       = 1'b0;
					remaining_n  = '0;
					tok_n.status = ST_APPLIED;
				end
			end
			FN_UNREGISTER: begin
				if (hit && present_q) begin
					present_n    = 1'b0;
					armed_n      = 1'b0;
					flag_n       = 1'b0;
					remaining_n  = '0;
					tok_n.status = ST_APPLIED;
				end
			end
			FN_ARM: begin
				if (hit && present_q && (tok_in.timeout_ms != '0)) begin
					armed_n      = 1'b1;
					remaining_n  = sat_count(tok_in.timeout_ms);
					tok_n.status = ST_APPLIED;
				end
			end
			FN_DISARM: begin
				if (hit && present_q) begin
					armed_n      = 1'b0;
					remaining_n  = '0;
					tok_n.status = ST_APPLIED;
				end
			end
			FN_TICK: begin
				if (armed_q) begin
					remaining_n = rem_dec;
					if (rem_dec == '0) begin
						armed_n = 1'b0;
						flag_n  = 1'b1;
						fire    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		tok_n.fired_mask = tok_in.fired_mask | (mask_sel & {MASK_W{fire}});
		tok_n.flag_mask  = tok_in.flag_mask  | (mask_sel & {MASK_W{flag_n}});
		tok_n.armed_mask = tok_in.armed_mask | (mask_sel & {MASK_W{armed_n}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= 1'b0;
			armed_q     <= 1'b0;
			flag_q      <= 1'b0;
			remaining_q <= '0;
		end else if (load) begin
			present_q   <= present_n;
			armed_q     <= armed_n;
			flag_q      <= flag_n;
			remaining_q <= remaining_n;
		end
	end

	// token register of this stage
	always_ff @(posedge clk) begin
		if (load) begin
			tok_out <= tok_n;
		end
	end

endmodule

// ===== hdl/multi_channel_timeout_watchdog_top.sv =====
// ----------------------------------------------------------------------------
// multi_channel_timeout_watchdog_top
// table of watchdog channels built as a row of channel cells
// ----------------------------------------------------------------------------
// usage
//   req carries one operation per transfer: register, unregister, arm,
//   disarm or a one millisecond tick, with a channel index and a timeout.
//   rsp returns exactly one result per operation, in order: the channels
//   that expired on it, the sticky flags and the armed bits afterwards,
//   and whether it was applied or ignored.
// pipeline
//   an operation walks the row one cell per cycle while the next stage
//   can take it, channel 0 first; each cell applies it to its own channel
//   and adds its bits to the result, and the last cell holds it on rsp.
//   the row is a pipeline, so a new operation can be taken in every
//   cycle while req.ready is high: one transfer per cycle.
// reset
//   arst_n clears every channel (absent, disarmed, count and flag zero)
//   and empties the row; no result is pending afterwards.
// stall
//   while rsp is held off the last stage keeps its result; earlier stages
//   keep moving into empty slots, and req.ready drops only once the whole
//   row is full.
// ----------------------------------------------------------------------------
module multi_channel_timeout_watchdog_top (
	input  logic      clk,
	input  logic      arst_n,
	mctw_req_if.sink  req,
	mctw_rsp_if.source rsp
);
	import mctw_pkg::*;

	// stage occupancy and per-stage move control
	logic [CHANNELS-1:0] vld_q;
	logic [CHANNELS-1:0] free;
	logic [CHANNELS-1:0] load;

	token_t tok_in  [CHANNELS];
	token_t tok_out [CHANNELS];
	token_t req_tok;

	// fresh token: masks start empty, a tick is applied by definition,
	// everything else stays ignored unless its channel's cell takes it
	always_comb begin
		req_tok            = '0;
		req_tok.func       = req.func;
		req_tok.channel    = req.channel;
		req_tok.timeout_ms = req.timeout_ms;
		req_tok.status     = (req.func == FN_TICK) ? ST_APPLIED : ST_IGNORED;
	end

	// a stage can take a token if it is empty or its token moves on
	always_comb begin
		free[CHANNELS-1] = !vld_q[CHANNELS-1] || rsp.ready;
		for (int k = CHANNELS - 2; k >= 0; k--) begin
			free[k] = !vld_q[k] || free[k+1];
		end
	end

	always_comb begin
		load[0] = req.valid && free[0];
		for (int k = 1; k < CHANNELS; k++) begin
			load[k] = vld_q[k-1] && free[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= load | (vld_q & ~free);
		end
	end

	// the row of channel cells
	for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
		localparam logic  ADDRESSABLE = (g < MASK_W);
		localparam logic [2:0] CODE   = 3'(g);
		localparam mask_t SEL         = (g < MASK_W) ? mask_t'(1 << g) : '0;

		if (g == 0) begin : g_head
			assign tok_in[g] = req_tok;
		end else begin : g_link
			assign tok_in[g] = tok_out[g-1];
		end

		mctw_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (load[g]),
			.addressable (ADDRESSABLE),
			.ch_code     (CODE),
			.mask_sel    (SEL),
			.tok_in      (tok_in[g]),
			.tok_out     (tok_out[g])
		);
	end

	// last stage doubles as the output register
	assign req.ready      = free[0];
	assign rsp.valid      = vld_q[CHANNELS-1];
	assign rsp.fired_mask = tok_out[CHANNELS-1].fired_mask;
	assign rsp.flag_mask  = tok_out[CHANNELS-1].flag_mask;
	assign rsp.armed_mask = tok_out[CHANNELS-1].armed_mask;
	assign rsp.status     = tok_out[CHANNELS-1].status;

endmodule

// ===== hdl/mctw_checker.sv =====
// ----------------------------------------------------------------------------
// mctw_checker
// port-level checks of the watchdog results, bound to the top level
// ----------------------------------------------------------------------------
module mctw_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic [mctw_pkg::MASK_W-1:0] fired_mask,
	input logic [mctw_pkg::MASK_W-1:0] flag_mask,
	input logic [mctw_pkg::MASK_W-1:0] armed_mask,
	input logic                    status
);
	import mctw_pkg::*;

	// a held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(fired_mask)
		&& $stable(flag_mask) && $stable(armed_mask) && $stable(status))
		else $error("response changed while stalled");

	// only an applied tick can expire channels
	a_fire_applied: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (fired_mask != '0) |-> status == ST_APPLIED)
		else $error("expiry reported on an ignored operation");

	// an expired channel has disarmed itself
	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (fired_mask & armed_mask) == '0)
		else $error("expired channel still armed");

	// an expired channel has its sticky flag up
	a_fire_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (fired_mask & ~flag_mask) == '0)
		else $error("expired channel without its flag");

endmodule

bind multi_channel_timeout_watchdog_top mctw_checker u_mctw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.fired_mask (rsp.fired_mask),
	.flag_mask  (rsp.flag_mask),
	.armed_mask (rsp.armed_mask),
	.status     (rsp.status)
);
